[hw/rtl/tme_pkg.sv]
// Shared types, constants and helper functions of the tree minimum election node.
package tme_pkg;

   localparam int NODE_ID_BITS  = 8;
   localparam int VALUE_BITS    = 32;
   localparam int ID_SLOT_BITS  = 8;
   localparam int ID_SLOTS      = 8;
   localparam int IDS_BITS      = ID_SLOT_BITS * ID_SLOTS;
   localparam int SLOT_IDX_BITS = $clog2(ID_SLOTS);
   localparam int CNT_BITS      = 4;
   localparam int CSR_IDX_BITS  = 2;

   localparam int DEF_MAX_NEIGHBORS = 8;
   localparam int DEF_QUEUE_DEPTH   = 2;

   localparam logic [CNT_BITS-1:0] COUNT_RESET = CNT_BITS'(1);

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_MSG   = 1'b1;
   localparam logic TAG_MIN    = 1'b0;
   localparam logic TAG_RESULT = 1'b1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_NEIGHBOR_COUNT = 2'd0,
      CSR_NEIGHBOR_IDS   = 2'd1,
      CSR_OWN_VALUE      = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_SEND_MIN = 2'd0,
      KIND_ANNOUNCE = 2'd1,
      KIND_REPORT   = 2'd2,
      KIND_IGNORED  = 2'd3
   } kind_type;

   // One decoded work packet passed from the front end to the back end.
   typedef struct packed {
      kind_type                      kind;
      logic [NODE_ID_BITS-1:0]       dest;
      logic signed [VALUE_BITS-1:0]  value;
      logic                          decider;
      logic [NODE_ID_BITS-1:0]       target_id;
   } cmd_type;

   // Configuration seen by the back end.
   typedef struct packed {
      logic [CNT_BITS-1:0] neighbor_count;
      logic [IDS_BITS-1:0] neighbor_ids;
   } cfg_type;

   // Neighbour count as used: held within one and the slot count.
   function automatic logic [CNT_BITS-1:0] clamp_count(input logic [CNT_BITS-1:0] raw,
                                                       input logic [CNT_BITS-1:0] max_n);
      logic [CNT_BITS-1:0] n;
      n = raw;
      if (raw == '0) begin
         n = CNT_BITS'(1);
      end else if (raw > max_n) begin
         n = max_n;
      end
      return n;
   endfunction

   function automatic logic [NODE_ID_BITS-1:0] slot_id(input logic [IDS_BITS-1:0] ids,
                                                       input logic [SLOT_IDX_BITS-1:0] slot);
      return ids[ID_SLOT_BITS*slot +: NODE_ID_BITS];
   endfunction

endpackage

[hw/rtl/tme_ifs.sv]
// Handshake channel interfaces of the tree minimum election node.
interface tme_req_if import tme_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic [7:0]                   source_node;
   logic                         msg_tag;
   logic signed [VALUE_BITS-1:0] msg_value;

   modport source (output valid, mode, source_node, msg_tag, msg_value, input ready);
   modport sink   (input valid, mode, source_node, msg_tag, msg_value, output ready);
endinterface

interface tme_rsp_if import tme_pkg::*; ();
   logic                         valid;
   logic                         ready;
   kind_type                     kind;
   logic [7:0]                   dest_node;
   logic signed [VALUE_BITS-1:0] out_value;
   logic                         decider;
   logic                         last;

   modport source (output valid, kind, dest_node, out_value, decider, last, input ready);
   modport sink   (input valid, kind, dest_node, out_value, decider, last, output ready);
endinterface

interface tme_csr_if import tme_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [IDS_BITS-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/tme_front.sv]
// Front end: configuration registers, election state and classification of requests.
module tme_front import tme_pkg::*; #(
   parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
   input  logic         clock,
   input  logic         reset,
   tme_req_if.sink      req_ch,
   tme_csr_if.sink      csr_ch,
   input  logic         full,
   output logic         push,
   output cmd_type      cmd,
   output cfg_type      cfg
);

   localparam int SLOT_BITS = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

   typedef enum logic [1:0] {
      PH_IDLE, PH_COLLECT, PH_WAIT, PH_DONE
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic signed [VALUE_BITS-1:0] min_ff, min_in;
   logic [CNT_BITS-1:0]          rcvd_ff, rcvd_in;
   logic [MAX_NEIGHBORS-1:0]     mask_ff, mask_in;
   logic [SLOT_BITS-1:0]         target_ff, target_in;

   logic [CNT_BITS-1:0]          count_ff;
   logic [IDS_BITS-1:0]          ids_ff;
   logic signed [VALUE_BITS-1:0] own_ff;

   logic                         accept;
   logic [CNT_BITS-1:0]          n_used;
   logic [NODE_ID_BITS-1:0]      src;
   logic [NODE_ID_BITS-1:0]      tid;
   logic [MAX_NEIGHBORS-1:0]     slot_valid;
   logic [MAX_NEIGHBORS-1:0]     hit;
   logic [MAX_NEIGHBORS-1:0]     mask_clr;
   logic [SLOT_BITS-1:0]         first_slot;
   logic [CNT_BITS-1:0]          rcvd_inc;
   logic signed [VALUE_BITS-1:0] min_upd;

   assign req_ch.ready = !full;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && !full;
   assign cfg          = '{neighbor_count: count_ff, neighbor_ids: ids_ff};

   assign n_used   = clamp_count(count_ff, CNT_BITS'(MAX_NEIGHBORS));
   assign src      = req_ch.source_node[NODE_ID_BITS-1:0];
   assign tid      = slot_id(ids_ff, SLOT_IDX_BITS'(target_ff));
   assign rcvd_inc = rcvd_ff + CNT_BITS'(1);
   assign min_upd  = (req_ch.msg_value < min_ff) ? req_ch.msg_value : min_ff;

   always_comb begin
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
         slot_valid[i] = CNT_BITS'(i) < n_used;
         hit[i]        = slot_valid[i] && (slot_id(ids_ff, SLOT_IDX_BITS'(i)) == src);
      end
      mask_clr   = mask_ff & ~hit;
      first_slot = '0;
      for (int i = MAX_NEIGHBORS - 1; i >= 0; i--) begin
         if (mask_clr[i] && slot_valid[i]) begin
            first_slot = SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      min_in    = min_ff;
      rcvd_in   = rcvd_ff;
      mask_in   = mask_ff;
      target_in = target_ff;
      push      = 1'b0;
      cmd       = '{kind: KIND_IGNORED, dest: '0, value: min_ff, decider: 1'b0,
                    target_id: tid};
      if (accept) begin
         if (req_ch.mode == MODE_START) begin
            min_in    = own_ff;
            rcvd_in   = '0;
            mask_in   = slot_valid;
            target_in = '0;
            if (n_used == CNT_BITS'(1)) begin
               phase_in = PH_WAIT;
               push     = 1'b1;
               cmd.kind  = KIND_SEND_MIN;
               cmd.dest  = slot_id(ids_ff, '0);
               cmd.value = own_ff;
            end else begin
               phase_in = PH_COLLECT;
            end
         end else if (phase_ff == PH_COLLECT && req_ch.msg_tag == TAG_MIN) begin
            min_in  = min_upd;
            mask_in = mask_clr;
            rcvd_in = rcvd_inc;
            if (rcvd_inc >= n_used - CNT_BITS'(1)) begin
               phase_in  = PH_WAIT;
               target_in = first_slot;
               push      = 1'b1;
               cmd.kind  = KIND_SEND_MIN;
               cmd.dest  = slot_id(ids_ff, SLOT_IDX_BITS'(first_slot));
               cmd.value = min_upd;
            end
         end else if (phase_ff == PH_WAIT && src == tid) begin
            min_in      = min_upd;
            phase_in    = PH_DONE;
            push        = 1'b1;
            cmd.kind    = KIND_REPORT;
            cmd.value   = min_upd;
            cmd.decider = (req_ch.msg_tag == TAG_MIN);
         end else begin
            push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         min_ff    <= '0;
         rcvd_ff   <= '0;
         mask_ff   <= '0;
         target_ff <= '0;
         count_ff  <= COUNT_RESET;
         ids_ff    <= '0;
         own_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         min_ff    <= min_in;
         rcvd_ff   <= rcvd_in;
         mask_ff   <= mask_in;
         target_ff <= target_in;
         if (csr_ch.valid) begin
            unique case (csr_index_type'(csr_ch.index))
               CSR_NEIGHBOR_COUNT: count_ff <= csr_ch.data[CNT_BITS-1:0];
               CSR_NEIGHBOR_IDS:   ids_ff   <= csr_ch.data;
               CSR_OWN_VALUE:      own_ff   <= csr_ch.data[VALUE_BITS-1:0];
               default:            ;
            endcase
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_report_ends_run: assert property (@(posedge clock) disable iff (reset)
      (push && cmd.kind == KIND_REPORT) |=> phase_ff == PH_DONE)
      else $error("report issued but run not finished");
`endif

endmodule

[hw/rtl/tme_queue.sv]
// Small command queue between the front end and the back end.
module tme_queue import tme_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);

   cmd_type              mem_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ff, wr_in;
   logic [PTR_BITS-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("command queue written while full");
`endif

endmodule

[hw/rtl/tme_back.sv]
// Back end: turns queued commands into responses, walking the announcement list.
module tme_back import tme_pkg::*; #(
   parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    empty,
   input  cmd_type head,
   output logic    pop,
   tme_rsp_if.source rsp_ch
);

   localparam int SLOT_BITS = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

   logic                         valid_ff, valid_in;
   kind_type                     kind_ff, kind_in;
   logic [NODE_ID_BITS-1:0]      dest_ff, dest_in;
   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic                         decider_ff, decider_in;
   logic                         last_ff, last_in;
   logic                         busy_ff, busy_in;
   logic [MAX_NEIGHBORS-1:0]     ann_ff, ann_in;
   logic signed [VALUE_BITS-1:0] ann_value_ff, ann_value_in;

   logic                         out_free;
   logic [CNT_BITS-1:0]          n_used;
   logic [MAX_NEIGHBORS-1:0]     others;
   logic [MAX_NEIGHBORS-1:0]     pick;
   logic [MAX_NEIGHBORS-1:0]     rest;
   logic [SLOT_BITS-1:0]         sel;

   assign out_free = !valid_ff || rsp_ch.ready;
   assign n_used   = clamp_count(cfg.neighbor_count, CNT_BITS'(MAX_NEIGHBORS));

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.kind      = kind_ff;
   assign rsp_ch.dest_node = dest_ff;
   assign rsp_ch.out_value = value_ff;
   assign rsp_ch.decider   = decider_ff;
   assign rsp_ch.last      = last_ff;

   // Announcement targets: every used slot whose id differs from the answering neighbour.
   always_comb begin
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
         others[i] = (CNT_BITS'(i) < n_used) &&
                     (slot_id(cfg.neighbor_ids, SLOT_IDX_BITS'(i)) != head.target_id);
      end
      sel = '0;
      for (int i = MAX_NEIGHBORS - 1; i >= 0; i--) begin
         if (ann_ff[i]) begin
            sel = SLOT_BITS'(i);
         end
      end
      pick = MAX_NEIGHBORS'(1) << sel;
      rest = ann_ff & ~pick;
   end

   always_comb begin
      valid_in     = valid_ff;
      kind_in      = kind_ff;
      dest_in      = dest_ff;
      value_in     = value_ff;
      decider_in   = decider_ff;
      last_in      = last_ff;
      busy_in      = busy_ff;
      ann_in       = ann_ff;
      ann_value_in = ann_value_ff;
      pop          = 1'b0;
      if (out_free) begin
         if (busy_ff) begin
            valid_in   = 1'b1;
            kind_in    = KIND_ANNOUNCE;
            dest_in    = slot_id(cfg.neighbor_ids, SLOT_IDX_BITS'(sel));
            value_in   = ann_value_ff;
            decider_in = 1'b0;
            last_in    = rest == '0;
            ann_in     = rest;
            busy_in    = rest != '0;
         end else if (!empty) begin
            pop        = 1'b1;
            valid_in   = 1'b1;
            kind_in    = head.kind;
            dest_in    = head.dest;
            value_in   = head.value;
            decider_in = head.decider;
            last_in    = 1'b1;
            if (head.kind == KIND_REPORT) begin
               last_in      = others == '0;
               ann_in       = others;
               busy_in      = others != '0;
               ann_value_in = head.value;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         busy_ff  <= 1'b0;
         ann_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         busy_ff  <= busy_in;
         ann_ff   <= ann_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      dest_ff      <= dest_in;
      value_ff     <= value_in;
      decider_ff   <= decider_in;
      last_ff      <= last_in;
      ann_value_ff <= ann_value_in;
   end

`ifndef NO_ASSERTIONS
   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ann_ff != '0)
      else $error("announcement walk active with nothing left");

   a_train_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last) |=>
         (rsp_ch.valid && rsp_ch.kind == KIND_ANNOUNCE))
      else $error("response train broken before its last transaction");
`endif

endmodule

[hw/rtl/tree_min_election_node_top.sv]
// Top level of the tree minimum election node.
//
//  Channel   Direction  Carries
//  req_ch    in         start or received message (mode, source_node, msg_tag, msg_value)
//  rsp_ch    out        send, announce, report or ignored (kind, dest_node, out_value,
//                       decider, last)
//  csr_ch    in         register write (index, data)
//
// The front end takes one request transaction per cycle while the command queue has room
// and settles the election state in that same cycle. A start that needs no send, or a
// minimum message that still leaves neighbours to hear from, produces no response.
// Every other request yields one response, registered in the back end's output register
// when the back end takes its command from the queue, after the queue has stored it,
// except the answer from the target neighbour: it gives a report followed by one
// announcement per remaining neighbour, one per cycle while rsp_ch is not stalled;
// the back end walks the announcement mask to issue them.
// Reset is synchronous and returns the state and configuration to their reset values; a stalled
// response holds in the output register while the front end keeps filling the queue.
module tree_min_election_node_top import tme_pkg::*; #(
   parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
   parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   tme_req_if.sink   req_ch,
   tme_rsp_if.source rsp_ch,
   tme_csr_if.sink   csr_ch
);

   // Command handed from the front end to the queue, and the queue head to the back end.
   logic    push;
   logic    full;
   logic    pop;
   logic    empty;
   cmd_type cmd;
   cmd_type head;
   cfg_type cfg;

   // The front end owns the registers and classifies every request transaction.
   tme_front #(
      .MAX_NEIGHBORS (MAX_NEIGHBORS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .full   (full),
      .push   (push),
      .cmd    (cmd),
      .cfg    (cfg)
   );

   // The queue lets the front end carry on while the back end is stalled.
   tme_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cmd),
      .full      (full),
      .pop       (pop),
      .pop_data  (head),
      .empty     (empty)
   );

   // The back end expands each command into response transactions.
   tme_back #(
      .MAX_NEIGHBORS (MAX_NEIGHBORS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .empty  (empty),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
